// ===== sv/ipv4p_pkg.sv =====
// Shared types, codes and character helpers for the IPv4 dotted-text parser.
package ipv4p_pkg;

  // Result transfer width: four octets, part count, ok flag, fault code, padded to bytes
  localparam int unsigned OutW = 40;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEXPFX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_SKIP   = 3'd5
  } ipv4p_phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } ipv4p_radix_e;

  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_RANGE  = 2'd1,
    FLT_EMPTY  = 2'd2,
    FLT_STRAY  = 2'd3
  } ipv4p_fault_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [8:0] OctetMax = 9'd255;
  localparam logic [8:0] SatValue = 9'd256;
  localparam logic [1:0] LastIndex = 2'd3;
  localparam logic [4:0] NoDigit = 5'd16;

  // Parser state carried from one character to the next
  typedef struct packed {
    ipv4p_phase_e      phase;
    ipv4p_radix_e      radix;
    logic [8:0]        part_value;
    logic              minus_seen;
    logic [1:0]        part_index;
    logic [3:0][7:0]   octet_store;
    ipv4p_fault_e      first_fault;
    logic [2:0]        fault_parts;
  } ipv4p_state_t;

  // Fields of one result item
  typedef struct packed {
    logic [3:0][7:0]   octets;
    logic [2:0]        parts_seen;
    logic              parse_ok;
    ipv4p_fault_e      fault_kind;
  } ipv4p_result_t;

  localparam ipv4p_state_t StateReset = '{
    phase:       PH_START,
    radix:       RX_DEC,
    part_value:  9'd0,
    minus_seen:  1'b0,
    part_index:  2'd0,
    octet_store: '0,
    first_fault: FLT_NONE,
    fault_parts: 3'd0
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Hex digit value of c, or NoDigit when c is not a hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      t = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      t = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      t = c - 8'h37;
    end else begin
      t = {3'd0, NoDigit};
    end
    return t[4:0];
  endfunction

  function automatic logic [4:0] base_of(input ipv4p_radix_e r);
    logic [4:0] b;
    case (r)
      RX_HEX:  b = 5'd16;
      RX_OCT:  b = 5'd8;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

  // One digit step of the accumulator, saturating just above one octet
  function automatic logic [8:0] accumulate(input logic [8:0] value,
                                            input ipv4p_radix_e r,
                                            input logic [4:0] d);
    logic [13:0] v;
    v = 14'(value) * 14'(base_of(r)) + 14'(d);
    return (v > 14'(OctetMax)) ? SatValue : v[8:0];
  endfunction

endpackage

// ===== sv/ipv4p_step.sv =====
// Per-character next-state and result logic of the IPv4 dotted-text parser.
module ipv4p_step import ipv4p_pkg::*; (
  input  ipv4p_state_t  state_i,
  input  logic [7:0]    char_i,
  output ipv4p_state_t  state_o,
  output ipv4p_result_t result_o
);

  ipv4p_state_t nxt;
  logic         end_req;
  logic         fail_req;
  ipv4p_fault_e fail_kind;
  logic [2:0]   fail_parts;
  logic [4:0]   d;
  logic [2:0]   index_plus;

  assign d          = digit_of(char_i);
  assign index_plus = {1'b0, state_i.part_index} + 3'd1;

  // Advance the phase machine by one character
  always_comb begin
    nxt        = state_i;
    end_req    = 1'b0;
    fail_req   = 1'b0;
    fail_kind  = FLT_NONE;
    fail_parts = 3'd0;

    case (state_i.phase)
      PH_START, PH_SIGN: begin
        if ((state_i.phase == PH_START) && is_space(char_i)) begin
          // skip leading whitespace
        end else if ((state_i.phase == PH_START) &&
                     ((char_i == ChPlus) || (char_i == ChMinus))) begin
          nxt.minus_seen = (char_i == ChMinus);
          nxt.phase      = PH_SIGN;
        end else if (char_i == ChZero) begin
          nxt.radix      = RX_OCT;
          nxt.part_value = 9'd0;
          nxt.phase      = PH_ZERO;
        end else if ((d >= 5'd1) && (d <= 5'd9)) begin
          nxt.radix      = RX_DEC;
          nxt.part_value = {4'd0, d};
          nxt.phase      = PH_DIGITS;
        end else begin
          fail_req   = 1'b1;
          fail_kind  = FLT_EMPTY;
          fail_parts = {1'b0, state_i.part_index};
        end
      end
      PH_ZERO: begin
        if ((char_i == ChLowX) || (char_i == ChUpX)) begin
          nxt.phase = PH_HEXPFX;
        end else if (d < 5'd8) begin
          nxt.part_value = accumulate(state_i.part_value, state_i.radix, d);
          nxt.phase      = PH_DIGITS;
        end else begin
          end_req = 1'b1;
        end
      end
      PH_HEXPFX: begin
        if (d < NoDigit) begin
          nxt.radix      = RX_HEX;
          nxt.part_value = {4'd0, d};
          nxt.phase      = PH_DIGITS;
        end else begin
          fail_req   = 1'b1;
          fail_kind  = FLT_STRAY;
          fail_parts = index_plus;
        end
      end
      PH_DIGITS: begin
        if (d < base_of(state_i.radix)) begin
          nxt.part_value = accumulate(state_i.part_value, state_i.radix, d);
        end else begin
          end_req = 1'b1;
        end
      end
      default: begin
        // ignore characters after a fault
      end
    endcase

    // Close a part that has digits
    if (end_req) begin
      if ((state_i.part_value > OctetMax) ||
          (state_i.minus_seen && (state_i.part_value != 9'd0))) begin
        fail_req   = 1'b1;
        fail_kind  = FLT_RANGE;
        fail_parts = {1'b0, state_i.part_index};
      end else begin
        nxt.octet_store[state_i.part_index] = state_i.part_value[7:0];
        if (char_i != ChNul) begin
          if ((char_i == ChDot) && (state_i.part_index < LastIndex)) begin
            nxt.part_index = state_i.part_index + 2'd1;
            nxt.phase      = PH_START;
            nxt.radix      = RX_DEC;
            nxt.part_value = 9'd0;
            nxt.minus_seen = 1'b0;
          end else begin
            fail_req   = 1'b1;
            fail_kind  = FLT_STRAY;
            fail_parts = index_plus;
          end
        end
      end
    end

    // Record only the first fault, then skip to the end of the string
    if (fail_req) begin
      if (state_i.first_fault == FLT_NONE) begin
        nxt.first_fault = fail_kind;
        nxt.fault_parts = fail_parts;
      end
      nxt.phase = PH_SKIP;
    end
  end

  // Build the result and restart on the string end
  always_comb begin
    if (nxt.first_fault == FLT_NONE) begin
      result_o.octets     = nxt.octet_store;
      result_o.parts_seen = {1'b0, nxt.part_index} + 3'd1;
      result_o.parse_ok   = 1'b1;
      result_o.fault_kind = FLT_NONE;
    end else begin
      result_o.octets     = '0;
      result_o.parts_seen = nxt.fault_parts;
      result_o.parse_ok   = 1'b0;
      result_o.fault_kind = nxt.first_fault;
    end
    state_o = (char_i == ChNul) ? StateReset : nxt;
  end

endmodule

// ===== sv/ipv4_dotted_text_parser_top.sv =====
// Top level of the IPv4 dotted-text parser: input register, step logic, result register.
//
//  channel   dir  width  fields (lowest bit first)
//  s_axis    in   8      text_char[7:0]
//  m_axis    out  40     octet_a, octet_b, octet_c, octet_d, parts_seen[2:0],
//                        parse_ok, fault_kind[1:0], 2 zero bits
//
//  One character per cycle unless a NUL waits on a stalled result. Each goes through the
//  input register and the combinational step logic; a NUL gives a result, held in the
//  result register, and other characters give none. Reset clears the parser state and
//  both valid flags. A stalled result holds a waiting NUL and all input behind it.
module ipv4_dotted_text_parser_top import ipv4p_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // text_char[7:0]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // octet_a[7:0], octet_b[15:8], octet_c[23:16],
                                          // octet_d[31:24], parts_seen[34:32], parse_ok[35],
                                          // fault_kind[37:36], zero[39:38]
);

  logic            in_valid_q;
  logic [7:0]      char_q;
  ipv4p_state_t    state_q;
  ipv4p_state_t    state_d;
  ipv4p_result_t   result;
  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic            is_nul;
  logic            advance;

  ipv4p_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Move the held character on unless it ends a string and the result slot is full
  assign is_nul        = (char_q == ChNul);
  assign advance       = in_valid_q && (!is_nul || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      char_q <= s_axis_tdata;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_nul) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance && is_nul) begin
      out_data_q <= {2'b00, result.fault_kind, result.parse_ok, result.parts_seen,
                     result.octets[3], result.octets[2], result.octets[1],
                     result.octets[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/ipv4p_checker.sv =====
// Port-level checks on the IPv4 dotted-text parser, bound to its top level.
module ipv4p_checker import ipv4p_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic [7:0]      s_axis_tdata,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  // Hold a stalled result transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A good address carries no fault code and at least one part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[35] |->
      (m_axis_tdata[37:36] == FLT_NONE) && (m_axis_tdata[34:32] != 3'd0))
    else $error("ok result with fault or no parts");

  // A failed parse names its fault and shows zero octets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[35] |->
      (m_axis_tdata[37:36] != FLT_NONE) && (m_axis_tdata[31:0] == 32'd0))
    else $error("failed result without fault code or with octets");

  // Part count never goes above four, padding stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      !(m_axis_tdata[34] && (m_axis_tdata[33:32] != 2'd0)) &&
      (m_axis_tdata[39:38] == 2'b00))
    else $error("part count or padding out of range");

  // A result rises only after a NUL was taken in through the input register, or while the input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready &&
                                   (s_axis_tdata == ChNul), 2) ||
                             $past(!s_axis_tready, 1))
    else $error("result without string end");

endmodule

bind ipv4_dotted_text_parser_top ipv4p_checker u_ipv4p_checker (.*);

// ===== dv/tb_ipv4_dotted_text_parser_top.sv =====
// Self-checking testbench for the IPv4 dotted-text parser: character stream in, address out.
module tb_ipv4_dotted_text_parser_top;
  import ipv4p_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseChars  = 207;
  localparam int unsigned ReportMax   = 10;

  // Fields of one parsed address, in the order they sit in m_axis_tdata
  typedef struct packed {
    logic [7:0]   a;
    logic [7:0]   b;
    logic [7:0]   c;
    logic [7:0]   d;
    logic [2:0]   parts;
    logic         ok;
    ipv4p_fault_e kind;
  } addr_result_t;

  // Tracks parser state per character and holds the addresses still owed by the block
  class addr_scoreboard;
    ipv4p_phase_e ph;
    ipv4p_radix_e rx;
    logic [8:0]   val;
    logic         neg;
    logic [1:0]   idx;
    logic [7:0]   octs [4];
    ipv4p_fault_e flt;
    logic [2:0]   flt_parts;
    addr_result_t expected_addrs [$];
    int unsigned  errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_START;
      rx = RX_DEC;
      val = '0;
      neg = 1'b0;
      idx = '0;
      foreach (octs[i]) octs[i] = '0;
      flt = FLT_NONE;
      flt_parts = '0;
    endfunction

    function int pending();
      return expected_addrs.size();
    endfunction

    function logic [4:0] char_digit(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return 5'(ch - "0");
      if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 10);
      if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 10);
      return NoDigit;
    endfunction

    function logic [4:0] radix_base();
      case (rx)
        RX_HEX:  return 5'd16;
        RX_OCT:  return 5'd8;
        default: return 5'd10;
      endcase
    endfunction

    // Keep only the first fault, then skip to the end of the string
    function void flag(ipv4p_fault_e kind, logic [2:0] parts);
      if (flt == FLT_NONE) begin
        flt = kind;
        flt_parts = parts;
      end
      ph = PH_SKIP;
    endfunction

    // Shift in one digit, pinning the value just above one octet
    function void take_digit(logic [4:0] dg);
      logic [13:0] v;
      v = 14'(val) * 14'(radix_base()) + 14'(dg);
      val = (v > 14'd255) ? 9'd256 : v[8:0];
    endfunction

    // Close a part that has digits on the character that ended it
    function void close_part(logic [7:0] ch);
      if (val > 9'd255 || (neg && val != '0)) begin
        flag(FLT_RANGE, 3'(idx));
        return;
      end
      octs[idx] = val[7:0];
      if (ch == ChNul) return;
      if (ch == ChDot && idx < LastIndex) begin
        idx++;
        ph = PH_START;
        rx = RX_DEC;
        val = '0;
        neg = 1'b0;
      end else begin
        flag(FLT_STRAY, 3'(idx) + 3'd1);
      end
    endfunction

    // Advance on one accepted character; a NUL owes one address
    function void parse_char(logic [7:0] ch);
      logic [4:0]   dg;
      logic         blank;
      addr_result_t r;
      dg = char_digit(ch);
      blank = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
      case (ph)
        PH_START, PH_SIGN: begin
          if (ph == PH_START && blank) begin
          end else if (ph == PH_START && (ch == ChPlus || ch == ChMinus)) begin
            neg = (ch == ChMinus);
            ph = PH_SIGN;
          end else if (ch == ChZero) begin
            rx = RX_OCT;
            val = '0;
            ph = PH_ZERO;
          end else if (dg >= 5'd1 && dg <= 5'd9) begin
            rx = RX_DEC;
            val = 9'(dg);
            ph = PH_DIGITS;
          end else begin
            flag(FLT_EMPTY, 3'(idx));
          end
        end
        PH_ZERO: begin
          if (ch == ChLowX || ch == ChUpX) begin
            ph = PH_HEXPFX;
          end else if (dg < 5'd8) begin
            take_digit(dg);
            ph = PH_DIGITS;
          end else begin
            close_part(ch);
          end
        end
        PH_HEXPFX: begin
          if (dg < 5'd16) begin
            rx = RX_HEX;
            val = 9'(dg);
            ph = PH_DIGITS;
          end else begin
            flag(FLT_STRAY, 3'(idx) + 3'd1);
          end
        end
        PH_DIGITS: begin
          if (dg < radix_base()) take_digit(dg);
          else close_part(ch);
        end
        default: begin
        end
      endcase
      if (ch != ChNul) return;
      if (flt == FLT_NONE) begin
        r = '{a: octs[0], b: octs[1], c: octs[2], d: octs[3],
              parts: 3'(idx) + 3'd1, ok: 1'b1, kind: FLT_NONE};
      end else begin
        r = '{a: '0, b: '0, c: '0, d: '0, parts: flt_parts, ok: 1'b0, kind: flt};
      end
      expected_addrs.push_back(r);
      clear();
    endfunction

    // Compare one output transfer against the oldest owed address
    function void check_result(logic [OutW-1:0] td);
      addr_result_t got;
      addr_result_t want;
      got = '{a: td[7:0], b: td[15:8], c: td[23:16], d: td[31:24],
              parts: td[34:32], ok: td[35], kind: ipv4p_fault_e'(td[37:36])};
      if (expected_addrs.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("unexpected result: %0d.%0d.%0d.%0d parts=%0d ok=%0b fault=%0d",
                   got.a, got.b, got.c, got.d, got.parts, got.ok, got.kind);
        return;
      end
      want = expected_addrs.pop_front();
      if (got.a != want.a || got.b != want.b || got.c != want.c || got.d != want.d ||
          got.parts != want.parts || got.ok != want.ok || got.kind != want.kind) begin
        errors++;
        if (errors <= ReportMax) begin
          $display("mismatch expected: %0d.%0d.%0d.%0d parts=%0d ok=%0b fault=%0d",
                   want.a, want.b, want.c, want.d, want.parts, want.ok, want.kind);
          $display("mismatch actual:   %0d.%0d.%0d.%0d parts=%0d ok=%0b fault=%0d",
                   got.a, got.b, got.c, got.d, got.parts, got.ok, got.kind);
        end
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  addr_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    chars_sent = 0;
  bit             hold_req = 1'b0;

  ipv4_dotted_text_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Offer one character, idling at random first, and hold it until the transfer
  task automatic push_char(input logic [7:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.parse_char(ch);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(ChNul);
  endtask

  // Drop valid and wait until every owed address has been taken
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One part: optional blanks and sign, then mostly a number in a random radix, sometimes nothing or a bare hex prefix
  function automatic string make_part();
    string       s;
    int unsigned v;
    int unsigned r;
    string       h;
    s = "";
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      r = $urandom_range(0, 5);
      s = {s, $sformatf("%c", (r == 5) ? 8'h20 : 8'(8'h09 + r))};
    end
    if ($urandom_range(0, 99) < 15) s = {s, $urandom_range(0, 1) ? "-" : "+"};
    r = $urandom_range(0, 99);
    if (r < 4) return s;
    if (r < 8) return {s, $urandom_range(0, 1) ? "0x" : "0X"};
    r = $urandom_range(0, 99);
    if (r < 70)      v = $urandom_range(0, 255);
    else if (r < 80) v = $urandom_range(0, 9);
    else if (r < 92) v = $urandom_range(256, 999);
    else             v = $urandom_range(1000, 4095);
    case ($urandom_range(0, 2))
      0: s = {s, $sformatf("%0d", v)};
      1: s = {s, $urandom_range(0, 3) == 0 ? "00" : "0", $sformatf("%0o", v)};
      default: begin
        h = $sformatf("%0h", v);
        if ($urandom_range(0, 1)) h = h.toupper();
        if ($urandom_range(0, 3) == 0) h = {"0", h};
        s = {s, $urandom_range(0, 1) ? "0x" : "0X", h};
      end
    endcase
    return s;
  endfunction

  // Mostly well-formed addresses, some corrupted, some pure noise
  function automatic string make_address();
    string       s;
    int unsigned n;
    int unsigned pos;
    s = "";
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(0, 8)) s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
      return s;
    end
    n = ($urandom_range(0, 99) < 8) ? 5 : ($urandom_range(0, 1) ? 4 : $urandom_range(1, 4));
    for (int i = 0; i < n; i++) s = (i == 0) ? make_part() : {s, ".", make_part()};
    if (s.len() > 0 && $urandom_range(0, 99) < 12) begin
      pos = $urandom_range(0, s.len() - 1);
      s[pos] = 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 99) < 5) s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
    return s;
  endfunction

  // Output side: check each transfer, then pick tready for the next cycle
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // End the run when no transfer happens on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus: directed corner strings, then random addresses over four phases of input idling and output stalls
  initial begin
    int unsigned idle_pct [4];
    int unsigned stall_pct [4];
    idle_pct  = '{0, 45, 0, 22};
    stall_pct = '{0, 0, 45, 22};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, bare hex prefix, saturation, negative, bad octal digit,
    // sign then blank, plain octal, top character code
    send_text("");
    send_text("0x");
    send_text("256");
    send_text("-1");
    send_text("08");
    send_text("+ ");
    send_text("0377");
    push_char(8'hFF);
    push_char(ChNul);
    settle();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      // output held off while strings keep coming, so the input backs up
      if (p == 0) begin
        hold_req = 1'b1;
        repeat (12) send_text(make_address());
      end
      while (chars_sent < 24 + PhaseChars * (p + 1)) send_text(make_address());
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
